>>> rtl/avc_a2b_pkg.sv
package avc_a2b_pkg;

  typedef enum logic [9:0] {
    PH_HEADER    = 10'b00_0000_0001,
    PH_SPS_HI    = 10'b00_0000_0010,
    PH_SPS_LO    = 10'b00_0000_0100,
    PH_SPS_PAY   = 10'b00_0000_1000,
    PH_PPS_COUNT = 10'b00_0001_0000,
    PH_PPS_HI    = 10'b00_0010_0000,
    PH_PPS_LO    = 10'b00_0100_0000,
    PH_PPS_PAY   = 10'b00_1000_0000,
    PH_DONE      = 10'b01_0000_0000,
    PH_SURPLUS   = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    STRM_NONE  = 2'd0,
    STRM_BYTE  = 2'd1,
    STRM_START = 2'd2
  } strm_op_t;

  localparam logic [2:0] HdrProfileIdx = 3'd1;
  localparam logic [2:0] HdrLevelIdx   = 3'd3;
  localparam logic [2:0] HdrNalIdx     = 3'd4;
  localparam logic [2:0] HdrLastIdx    = 3'd5;

  localparam logic [2:0] NalSizeReset  = 3'd1;
  localparam logic [2:0] StartCodeLen  = 3'd4;
  localparam logic [1:0] StartCodeLast = 2'd3;
  localparam logic [7:0] StartCodeOne  = 8'h01;

  // one queued command: optional stream part then optional status part
  typedef struct packed {
    strm_op_t   op;
    logic [7:0] data;
    logic       is_pps;
    logic       set_end;
    logic       status;
    logic [7:0] profile;
    logic [7:0] level;
    logic [2:0] nal_size;
    logic       length_error;
  } cmd_t;

  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    start_code_byte = (idx == StartCodeLast) ? StartCodeOne : 8'h00;
  endfunction

endpackage

>>> rtl/avc_a2b_if.sv
interface avc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface avc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       is_pps;
  logic       set_end;
  logic [7:0] profile;
  logic [7:0] level;
  logic [2:0] nal_length_size;
  logic       length_error;

  modport source (output valid, output kind, output out_byte, output is_pps,
                  output set_end, output profile, output level,
                  output nal_length_size, output length_error, input ready);
  modport sink   (input valid, input kind, input out_byte, input is_pps,
                  input set_end, input profile, input level,
                  input nal_length_size, input length_error, output ready);
endinterface

>>> rtl/avc_config_to_annexb.sv
// channel   dir  handshake          payload
// in_s      in   valid / ready      in_byte, last_byte
// out_m     out  valid / ready      kind, out_byte, is_pps, set_end, profile,
//                                   level, nal_length_size, length_error
//
// Takes one record byte per cycle while the queue is not full; each byte is
// classified in the cycle it is accepted and, if it yields output, queued as
// one command. The output register delivers one result per cycle while the
// queue is not empty and out_m.ready allows; a start code yields four bytes.
// The QUEUE_DEPTH command queue absorbs start code bursts; in_s.ready drops
// only while it is full.
// Synchronous active-low reset returns the parser to the header and empties
// the queue and output register.
module avc_config_to_annexb #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  avc_in_if.sink    in_s,
  avc_out_if.source out_m
);

  avc_a2b_pkg::cmd_t wr_cmd, head;
  logic              push, full, empty, pop;

  avc_a2b_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .cmd      (wr_cmd),
    .cmd_push (push),
    .cmd_full (full)
  );

  avc_a2b_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cmd (wr_cmd),
    .push   (push),
    .full   (full),
    .head   (head),
    .empty  (empty),
    .pop    (pop)
  );

  avc_a2b_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out_m (out_m)
  );

endmodule

>>> rtl/avc_a2b_front.sv
module avc_a2b_front (
  input  logic                clk,
  input  logic                rst_n,
  avc_in_if.sink              in_s,
  output avc_a2b_pkg::cmd_t   cmd,
  output logic                cmd_push,
  input  logic                cmd_full
);

  avc_a2b_pkg::phase_t phase_r, phase_nxt, finish_phase;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  sets_left_r, sets_left_nxt, sets_dec;
  logic [15:0] bytes_left_r, bytes_left_nxt, set_len, bytes_dec;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  profile_r, profile_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [2:0]  nal_size_r, nal_size_nxt;
  logic        pps_ph;
  logic        accept;
  logic [7:0]  b;

  assign in_s.ready = !cmd_full;
  assign accept     = in_s.valid && in_s.ready;
  assign b          = in_s.in_byte;

  assign pps_ph    = (phase_r == avc_a2b_pkg::PH_PPS_LO) ||
                     (phase_r == avc_a2b_pkg::PH_PPS_PAY);
  assign sets_dec  = sets_left_r - 8'd1;
  assign set_len   = {len_hi_r, b};
  assign bytes_dec = bytes_left_r - 16'd1;

  always_comb begin
    if (sets_dec != 8'd0) begin
      finish_phase = pps_ph ? avc_a2b_pkg::PH_PPS_HI : avc_a2b_pkg::PH_SPS_HI;
    end else begin
      finish_phase = pps_ph ? avc_a2b_pkg::PH_DONE : avc_a2b_pkg::PH_PPS_COUNT;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    sets_left_nxt  = sets_left_r;
    bytes_left_nxt = bytes_left_r;
    len_hi_nxt     = len_hi_r;
    profile_nxt    = profile_r;
    level_nxt      = level_r;
    nal_size_nxt   = nal_size_r;
    cmd            = '0;
    cmd.op         = avc_a2b_pkg::STRM_NONE;
    cmd.is_pps     = pps_ph;

    unique case (phase_r)
      avc_a2b_pkg::PH_HEADER: begin
        if (hdr_cnt_r == avc_a2b_pkg::HdrProfileIdx) profile_nxt = b;
        if (hdr_cnt_r == avc_a2b_pkg::HdrLevelIdx)   level_nxt   = b;
        if (hdr_cnt_r == avc_a2b_pkg::HdrNalIdx) begin
          nal_size_nxt = {1'b0, b[1:0]} + 3'd1;
        end
        if (hdr_cnt_r >= avc_a2b_pkg::HdrLastIdx) begin
          hdr_cnt_nxt   = 3'd0;
          sets_left_nxt = {3'b000, b[4:0]};
          phase_nxt     = (b[4:0] != 5'd0) ? avc_a2b_pkg::PH_SPS_HI
                                           : avc_a2b_pkg::PH_PPS_COUNT;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end
      end
      avc_a2b_pkg::PH_SPS_HI: begin
        len_hi_nxt = b;
        phase_nxt  = avc_a2b_pkg::PH_SPS_LO;
      end
      avc_a2b_pkg::PH_PPS_HI: begin
        len_hi_nxt = b;
        phase_nxt  = avc_a2b_pkg::PH_PPS_LO;
      end
      avc_a2b_pkg::PH_SPS_LO, avc_a2b_pkg::PH_PPS_LO: begin
        bytes_left_nxt = set_len;
        cmd.op         = avc_a2b_pkg::STRM_START;
        cmd.set_end    = (set_len == 16'd0);
        if (set_len == 16'd0) begin
          sets_left_nxt = sets_dec;
          phase_nxt     = finish_phase;
        end else begin
          phase_nxt = pps_ph ? avc_a2b_pkg::PH_PPS_PAY : avc_a2b_pkg::PH_SPS_PAY;
        end
      end
      avc_a2b_pkg::PH_SPS_PAY, avc_a2b_pkg::PH_PPS_PAY: begin
        bytes_left_nxt = bytes_dec;
        cmd.op         = avc_a2b_pkg::STRM_BYTE;
        cmd.data       = b;
        cmd.set_end    = (bytes_dec == 16'd0);
        if (bytes_dec == 16'd0) begin
          sets_left_nxt = sets_dec;
          phase_nxt     = finish_phase;
        end
      end
      avc_a2b_pkg::PH_PPS_COUNT: begin
        sets_left_nxt = b;
        phase_nxt     = (b != 8'd0) ? avc_a2b_pkg::PH_PPS_HI : avc_a2b_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = avc_a2b_pkg::PH_SURPLUS;
      end
    endcase

    cmd.status       = in_s.last_byte;
    cmd.profile      = profile_nxt;
    cmd.level        = level_nxt;
    cmd.nal_size     = nal_size_nxt;
    cmd.length_error = (phase_nxt != avc_a2b_pkg::PH_DONE);

    // record end: back to the reset state for the next record
    if (in_s.last_byte) begin
      phase_nxt      = avc_a2b_pkg::PH_HEADER;
      hdr_cnt_nxt    = 3'd0;
      sets_left_nxt  = 8'd0;
      bytes_left_nxt = 16'd0;
      len_hi_nxt     = 8'd0;
      profile_nxt    = 8'd0;
      level_nxt      = 8'd0;
      nal_size_nxt   = avc_a2b_pkg::NalSizeReset;
    end
  end

  assign cmd_push = accept && ((cmd.op != avc_a2b_pkg::STRM_NONE) || cmd.status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= avc_a2b_pkg::PH_HEADER;
      hdr_cnt_r    <= 3'd0;
      sets_left_r  <= 8'd0;
      bytes_left_r <= 16'd0;
      len_hi_r     <= 8'd0;
      profile_r    <= 8'd0;
      level_r      <= 8'd0;
      nal_size_r   <= avc_a2b_pkg::NalSizeReset;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      sets_left_r  <= sets_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      len_hi_r     <= len_hi_nxt;
      profile_r    <= profile_nxt;
      level_r      <= level_nxt;
      nal_size_r   <= nal_size_nxt;
    end
  end

endmodule

>>> rtl/avc_a2b_queue.sv
module avc_a2b_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  avc_a2b_pkg::cmd_t wr_cmd,
  input  logic              push,
  output logic              full,
  output avc_a2b_pkg::cmd_t head,
  output logic              empty,
  input  logic              pop
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  avc_a2b_pkg::cmd_t slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CntFull);
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CntW'(1);
    if (do_pop && !do_push) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_cmd;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntFull) else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("command pushed into full queue");
`endif

endmodule

>>> rtl/avc_a2b_back.sv
module avc_a2b_back (
  input  logic              clk,
  input  logic              rst_n,
  input  avc_a2b_pkg::cmd_t head,
  input  logic              empty,
  output logic              pop,
  avc_out_if.source         out_m
);

  logic [2:0] step_r;
  logic [2:0] strm_cnt, total;
  logic       adv, emit, is_last, is_strm;

  logic       out_valid_r;
  logic       kind_r;
  logic [7:0] byte_r;
  logic       is_pps_r;
  logic       set_end_r;
  logic [7:0] profile_r;
  logic [7:0] level_r;
  logic [2:0] nal_size_r;
  logic       len_err_r;

  always_comb begin
    unique case (head.op)
      avc_a2b_pkg::STRM_START: strm_cnt = avc_a2b_pkg::StartCodeLen;
      avc_a2b_pkg::STRM_BYTE:  strm_cnt = 3'd1;
      default:                 strm_cnt = 3'd0;
    endcase
  end

  assign total   = strm_cnt + {2'b00, head.status};
  assign is_last = (step_r == total - 3'd1);
  assign is_strm = (step_r < strm_cnt);
  assign adv     = !out_valid_r || out_m.ready;
  assign emit    = adv && !empty;
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= !empty;
      if (emit) step_r <= is_last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (is_strm) begin
        kind_r     <= 1'b0;
        byte_r     <= (head.op == avc_a2b_pkg::STRM_START) ?
                      avc_a2b_pkg::start_code_byte(step_r[1:0]) : head.data;
        is_pps_r   <= head.is_pps;
        set_end_r  <= (head.op == avc_a2b_pkg::STRM_START) ?
                      (head.set_end && step_r[1:0] == avc_a2b_pkg::StartCodeLast) :
                      head.set_end;
        profile_r  <= 8'd0;
        level_r    <= 8'd0;
        nal_size_r <= 3'd0;
        len_err_r  <= 1'b0;
      end else begin
        kind_r     <= 1'b1;
        byte_r     <= 8'd0;
        is_pps_r   <= 1'b0;
        set_end_r  <= 1'b0;
        profile_r  <= head.profile;
        level_r    <= head.level;
        nal_size_r <= head.nal_size;
        len_err_r  <= head.length_error;
      end
    end
  end

  assign out_m.valid           = out_valid_r;
  assign out_m.kind            = kind_r;
  assign out_m.out_byte        = byte_r;
  assign out_m.is_pps          = is_pps_r;
  assign out_m.set_end         = set_end_r;
  assign out_m.profile         = profile_r;
  assign out_m.level           = level_r;
  assign out_m.nal_length_size = nal_size_r;
  assign out_m.length_error    = len_err_r;

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> step_r < total) else $error("step beyond command length");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !is_strm) |-> is_last) else $error("status not last of command");
`endif

endmodule
